### hdl/lvtw_pkg.sv
// Shared types and constants for the line voxel track walker.
// Used by every module in hdl/; depends on nothing.
package lvtw_pkg;

    // Grid size in cubes
    localparam int GRID_X = 16;
    localparam int GRID_Y = 16;
    localparam int GRID_Z = 51;

    // Cube coordinate width (signed, holds one cube outside the grid)
    localparam int CW = 8;
    // Fraction bits of the Q16.16 line registers
    localparam int QF = 16;
    // Wide working width for plane arithmetic
    localparam int WW = 50;
    // Squared distance width
    localparam int DW = 2 * (CW + 1) + 2;

    // APB address width and register indexes
    localparam int ADDR_W = 5;
    localparam logic [ADDR_W-3:0] REG_SLOPE_X     = 3'd0;
    localparam logic [ADDR_W-3:0] REG_OFFSET_X    = 3'd1;
    localparam logic [ADDR_W-3:0] REG_SLOPE_Y     = 3'd2;
    localparam logic [ADDR_W-3:0] REG_OFFSET_Y    = 3'd3;
    localparam logic [ADDR_W-3:0] REG_INV_SLOPE_X = 3'd4;
    localparam logic [ADDR_W-3:0] REG_INV_SLOPE_Y = 3'd5;

    // Item modes
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // Faces in test order
    localparam logic [2:0] FACE_X_LO = 3'd0;
    localparam logic [2:0] FACE_Y_LO = 3'd1;
    localparam logic [2:0] FACE_Z_LO = 3'd2;
    localparam logic [2:0] FACE_X_HI = 3'd3;
    localparam logic [2:0] FACE_Y_HI = 3'd4;
    localparam logic [2:0] FACE_Z_HI = 3'd5;

    // Phases of one face test
    localparam logic [2:0] PH_OPS1 = 3'd0;
    localparam logic [2:0] PH_MUL1 = 3'd1;
    localparam logic [2:0] PH_T    = 3'd2;
    localparam logic [2:0] PH_OPS2 = 3'd3;
    localparam logic [2:0] PH_MUL2 = 3'd4;
    localparam logic [2:0] PH_HIT  = 3'd5;

    // Last neighbor offset of the start search
    localparam logic [1:0] OFF_MAX = 2'd2;

    typedef enum logic [2:0] {
        ERR_OK,
        ERR_NO_START,
        ERR_OUT_OF_VOLUME,
        ERR_NO_EXIT,
        ERR_ONE_EXIT,
        ERR_EXTRA_EXITS,
        ERR_SECOND_REVERSAL,
        ERR_NO_ALTERNATE
    } err_t;

    typedef struct packed {
        logic       mode;
        logic [3:0] seed_x;
        logic [3:0] seed_y;
        logic [5:0] seed_z;
        logic [3:0] goal_x;
        logic [3:0] goal_y;
        logic [5:0] goal_z;
    } item_t;

    typedef struct packed {
        logic [3:0] cube_x;
        logic [3:0] cube_y;
        logic [5:0] cube_z;
        logic       restart;
        logic       last;
        logic [2:0] error;
    } result_t;

    typedef struct packed {
        logic signed [31:0] slope_x;
        logic signed [31:0] offset_x;
        logic signed [31:0] slope_y;
        logic signed [31:0] offset_y;
        logic signed [31:0] inv_slope_x;
        logic signed [31:0] inv_slope_y;
    } cfg_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cube_t;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       mask_clr;
        logic       face_step;
        logic       best_upd;
        logic       finish;
        logic [2:0] face;
        logic [2:0] phase;
        logic [1:0] off_i;
        logic [1:0] off_j;
        logic [1:0] off_k;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_start;
        logic cand_in_vol;
        logic out_busy;
    } status_t;

endpackage

### hdl/line_voxel_track_walker_top.sv
// An advance word runs a prep step, the six faces on the single 32x32 multiplier and a
// finish step; on a cube outside the grid it goes from prep to finish. A start word runs
// prep, faces and an evaluation step for each of the 27 seed neighbors in the grid, prep
// and evaluation for each outside, then finish. One word is in flight at a time; finish
// waits while the output is not taken, and the next is accepted the cycle after the
// finish. Reset (rst_n, async low) clears the track state.
module line_voxel_track_walker_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lvtw_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  lvtw_pkg::item_t              item,
    output logic                         result_valid,
    input  logic                         result_ready,
    output lvtw_pkg::result_t            result
);
    import lvtw_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    // Configuration registers
    lvtw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer
    lvtw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Datapath
    lvtw_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

### hdl/lvtw_regs.sv
// APB configuration registers of the line voxel track walker.
// Depends on lvtw_pkg.
module lvtw_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lvtw_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output lvtw_pkg::cfg_t               cfg
);
    import lvtw_pkg::*;

    cfg_t             cfg_reg;
    logic [ADDR_W-3:0] idx;

    assign idx    = paddr[ADDR_W-1:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slope_x     <= 32'sh0001_0000;
            cfg_reg.offset_x    <= '0;
            cfg_reg.slope_y     <= 32'sh0001_0000;
            cfg_reg.offset_y    <= '0;
            cfg_reg.inv_slope_x <= 32'sh0001_0000;
            cfg_reg.inv_slope_y <= 32'sh0001_0000;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (idx)
                REG_SLOPE_X:     cfg_reg.slope_x     <= pwdata;
                REG_OFFSET_X:    cfg_reg.offset_x    <= pwdata;
                REG_SLOPE_Y:     cfg_reg.slope_y     <= pwdata;
                REG_OFFSET_Y:    cfg_reg.offset_y    <= pwdata;
                REG_INV_SLOPE_X: cfg_reg.inv_slope_x <= pwdata;
                REG_INV_SLOPE_Y: cfg_reg.inv_slope_y <= pwdata;
                default:         ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            REG_SLOPE_X:     prdata = cfg_reg.slope_x;
            REG_OFFSET_X:    prdata = cfg_reg.offset_x;
            REG_SLOPE_Y:     prdata = cfg_reg.slope_y;
            REG_OFFSET_Y:    prdata = cfg_reg.offset_y;
            REG_INV_SLOPE_X: prdata = cfg_reg.inv_slope_x;
            REG_INV_SLOPE_Y: prdata = cfg_reg.inv_slope_y;
            default:         prdata = '0;
        endcase
    end

endmodule

### hdl/lvtw_ctrl.sv
// Sequencer of the line voxel track walker: candidates, faces, phases.
// Depends on lvtw_pkg; drives lvtw_dp through cmd_t and reads status_t.
module lvtw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  lvtw_pkg::status_t status,
    output lvtw_pkg::cmd_t    cmd
);
    import lvtw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_FACE,
        S_EVAL,
        S_FIN
    } state_t;

    state_t     state_reg;
    logic [2:0] face_reg;
    logic [2:0] phase_reg;
    logic [1:0] off_i_reg;
    logic [1:0] off_j_reg;
    logic [1:0] off_k_reg;

    assign item_ready = (state_reg == S_IDLE);

    // Commands follow the state
    always_comb
    begin
        cmd.load      = item_valid && item_ready;
        cmd.mask_clr  = (state_reg == S_PREP);
        cmd.face_step = (state_reg == S_FACE);
        cmd.best_upd  = (state_reg == S_EVAL);
        cmd.finish    = (state_reg == S_FIN) && !status.out_busy;
        cmd.face      = face_reg;
        cmd.phase     = phase_reg;
        cmd.off_i     = off_i_reg;
        cmd.off_j     = off_j_reg;
        cmd.off_k     = off_k_reg;
    end

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            face_reg  <= FACE_X_LO;
            phase_reg <= PH_OPS1;
            off_i_reg <= '0;
            off_j_reg <= '0;
            off_k_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        off_i_reg <= '0;
                        off_j_reg <= '0;
                        off_k_reg <= '0;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    face_reg  <= FACE_X_LO;
                    phase_reg <= PH_OPS1;
                    if (status.cand_in_vol)
                        state_reg <= S_FACE;
                    else if (status.is_start)
                        state_reg <= S_EVAL;
                    else
                        state_reg <= S_FIN;
                end
                S_FACE:
                begin
                    if (phase_reg == PH_HIT)
                    begin
                        phase_reg <= PH_OPS1;
                        if (face_reg == FACE_Z_HI)
                            state_reg <= status.is_start ? S_EVAL : S_FIN;
                        else
                            face_reg <= face_reg + 3'd1;
                    end
                    else
                    begin
                        phase_reg <= phase_reg + 3'd1;
                    end
                end
                S_EVAL:
                begin
                    // Step to the next of the 27 neighbors
                    if (off_i_reg == OFF_MAX && off_j_reg == OFF_MAX && off_k_reg == OFF_MAX)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_PREP;
                        if (off_k_reg != OFF_MAX)
                        begin
                            off_k_reg <= off_k_reg + 2'd1;
                        end
                        else
                        begin
                            off_k_reg <= '0;
                            if (off_j_reg != OFF_MAX)
                            begin
                                off_j_reg <= off_j_reg + 2'd1;
                            end
                            else
                            begin
                                off_j_reg <= '0;
                                off_i_reg <= off_i_reg + 2'd1;
                            end
                        end
                    end
                end
                S_FIN:
                begin
                    if (!status.out_busy)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FACE |-> (face_reg <= FACE_Z_HI && phase_reg <= PH_HIT))
        else $error("face or phase counter out of range");

    a_eval_start_only: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVAL |-> status.is_start)
        else $error("candidate evaluation on an advance word");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && status.out_busy) |=> state_reg == S_FIN)
        else $error("finish left while the output word waits");
`endif

endmodule

### hdl/lvtw_dp.sv
// Datapath of the line voxel track walker: shared multiplier, face tests,
// start search, track state and output register. Depends on lvtw_pkg.
module lvtw_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  lvtw_pkg::cfg_t    cfg,
    input  lvtw_pkg::item_t   item,
    input  lvtw_pkg::cmd_t    cmd,
    output lvtw_pkg::status_t status,
    output lvtw_pkg::result_t result,
    output logic              result_valid,
    input  logic              result_ready
);
    import lvtw_pkg::*;

    localparam logic signed [WW-1:0] SAT_HI = {{(WW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [WW-1:0] SAT_LO = {{(WW-31){1'b1}}, {31{1'b0}}};
    localparam logic signed [WW-1:0] Q_STEP = {{(WW-QF-1){1'b0}}, 1'b1, {QF{1'b0}}};

    function automatic logic in_volume(cube_t c);
        return !c.x[CW-1] && (c.x < $signed(CW'(GRID_X)))
            && !c.y[CW-1] && (c.y < $signed(CW'(GRID_Y)))
            && !c.z[CW-1] && (c.z < $signed(CW'(GRID_Z)));
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [WW-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI)
            r = SAT_HI[31:0];
        else if (v < SAT_LO)
            r = SAT_LO[31:0];
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [WW-1:0] sx32(logic signed [31:0] v);
        return {{(WW-32){v[31]}}, v};
    endfunction

    // Strictly inside the open interval of cube coordinate c
    function automatic logic in_open(logic signed [WW-1:0] v, logic signed [CW-1:0] c);
        logic signed [WW-1:0] lo;
        lo = {{(WW-CW-QF){c[CW-1]}}, c, {QF{1'b0}}};
        return (v > lo) && (v < lo + Q_STEP);
    endfunction

    function automatic cube_t neighbor(cube_t c, logic [2:0] f);
        cube_t r;
        r = c;
        case (f)
            FACE_X_LO: r.x = c.x - CW'(1);
            FACE_Y_LO: r.y = c.y - CW'(1);
            FACE_Z_LO: r.z = c.z - CW'(1);
            FACE_X_HI: r.x = c.x + CW'(1);
            FACE_Y_HI: r.y = c.y + CW'(1);
            FACE_Z_HI: r.z = c.z + CW'(1);
            default:   r = c;
        endcase
        return r;
    endfunction

    item_t                item_reg;
    cube_t                cur_reg, prev_reg, first_reg, other_reg, end_reg, best_reg;
    logic                 prev_valid_reg, other_valid_reg, reversed_reg, found_reg;
    logic [5:0]           mask_reg;
    logic signed [31:0]   opa_reg, opb_reg;
    logic signed [63:0]   prod_reg;
    logic signed [WW-1:0] t_reg;
    logic [DW-1:0]        bestd_reg;
    result_t              out_reg;
    logic                 out_valid_reg;

    cube_t                seed_c, cand, e0, e1, nxt, back;
    logic                 is_start, ax_x, ax_y, is_hi, hit, start_hit;
    logic signed [CW-1:0] sel;
    logic signed [CW:0]   pc;
    logic signed [WW-1:0] plane_q, prod_hi, sum_a;
    logic signed [31:0]   opa, opb, off_a, off_b;
    logic signed [WW-1:0] t_new;
    logic [2:0]           n_exit;
    logic signed [DW-1:0] dxw, dyw, dzw;
    logic [DW-1:0]        sq_dist;
    logic signed [CW:0]   ex, ey, ez;
    logic                 near;
    err_t                 res_err;
    logic                 res_restart, first_act, ow_set, rev_act;

    assign is_start = (item_reg.mode == MODE_START);

    // Cube under test: a neighbor of the seed or the current cube
    always_comb
    begin
        seed_c.x = {{(CW-4){1'b0}}, item_reg.seed_x};
        seed_c.y = {{(CW-4){1'b0}}, item_reg.seed_y};
        seed_c.z = {{(CW-6){1'b0}}, item_reg.seed_z};
        if (is_start)
        begin
            cand.x = seed_c.x + CW'(cmd.off_i) - CW'(1);
            cand.y = seed_c.y + CW'(cmd.off_j) - CW'(1);
            cand.z = seed_c.z + CW'(cmd.off_k) - CW'(1);
        end
        else
        begin
            cand = cur_reg;
        end
    end

    // Face plane and multiplier operands
    always_comb
    begin
        ax_x    = (cmd.face == FACE_X_LO) || (cmd.face == FACE_X_HI);
        ax_y    = (cmd.face == FACE_Y_LO) || (cmd.face == FACE_Y_HI);
        is_hi   = (cmd.face >= FACE_X_HI);
        sel     = ax_x ? cand.x : (ax_y ? cand.y : cand.z);
        pc      = {sel[CW-1], sel} + $signed({{CW{1'b0}}, is_hi});
        plane_q = {{(WW-CW-1-QF){pc[CW]}}, pc, {QF{1'b0}}};
        prod_hi = {{(WW-64+QF){prod_reg[63]}}, prod_reg[63:QF]};
        off_a   = ax_y ? cfg.offset_y : cfg.offset_x;
        off_b   = ax_y ? cfg.offset_x : cfg.offset_y;
        if (cmd.phase == PH_OPS1)
        begin
            if (ax_x)
            begin
                opa = sat32(plane_q - sx32(cfg.offset_x));
                opb = cfg.inv_slope_x;
            end
            else if (ax_y)
            begin
                opa = sat32(plane_q - sx32(cfg.offset_y));
                opb = cfg.inv_slope_y;
            end
            else
            begin
                opa = cfg.slope_x;
                opb = plane_q[31:0];
            end
        end
        else
        begin
            opa = ax_y ? cfg.slope_x : cfg.slope_y;
            opb = (ax_x || ax_y) ? t_reg[31:0] : plane_q[31:0];
        end
        t_new = (ax_x || ax_y) ? sx32(sat32(prod_hi)) : prod_hi + sx32(off_a);
        sum_a = prod_hi + sx32(off_b);
        if (ax_x)
            hit = in_open(t_reg, cand.z) && in_open(sum_a, cand.y);
        else if (ax_y)
            hit = in_open(t_reg, cand.z) && in_open(sum_a, cand.x);
        else
            hit = in_open(t_reg, cand.x) && in_open(sum_a, cand.y);
    end

    // Exits in face order and their count
    always_comb
    begin
        n_exit = '0;
        e0     = cur_reg;
        e1     = cur_reg;
        for (int i = 0; i < 6; i++)
        begin
            if (mask_reg[i])
            begin
                if (n_exit == 3'd0)
                    e0 = neighbor(cur_reg, 3'(i));
                else if (n_exit == 3'd1)
                    e1 = neighbor(cur_reg, 3'(i));
                n_exit = n_exit + 3'd1;
            end
        end
    end

    // Squared distance of the candidate to the goal
    always_comb
    begin
        dxw       = DW'($signed({cand.x[CW-1], cand.x}) - $signed({1'b0, CW'(item_reg.goal_x)}));
        dyw       = DW'($signed({cand.y[CW-1], cand.y}) - $signed({1'b0, CW'(item_reg.goal_y)}));
        dzw       = DW'($signed({cand.z[CW-1], cand.z}) - $signed({1'b0, CW'(item_reg.goal_z)}));
        sq_dist   = DW'(dxw * dxw + dyw * dyw + dzw * dzw);
        start_hit = in_volume(cand) && (n_exit == 3'd2);
    end

    // Outcome of the word
    always_comb
    begin
        nxt         = cur_reg;
        res_err     = ERR_OK;
        res_restart = 1'b0;
        first_act   = 1'b0;
        ow_set      = 1'b0;
        rev_act     = 1'b0;
        back        = (e1 == prev_reg) ? e0 : e1;
        if (is_start)
        begin
            if (found_reg)
                nxt = best_reg;
            else
                res_err = ERR_NO_START;
        end
        else if (!in_volume(cur_reg))
            res_err = ERR_OUT_OF_VOLUME;
        else if (n_exit == 3'd0)
            res_err = ERR_NO_EXIT;
        else if (n_exit == 3'd1)
            res_err = ERR_ONE_EXIT;
        else if (n_exit > 3'd2)
            res_err = ERR_EXTRA_EXITS;
        else if (!prev_valid_reg)
        begin
            first_act = 1'b1;
            if (in_volume(e0) && in_volume(e1))
            begin
                ow_set = 1'b1;
                nxt    = e0;
            end
            else if (!in_volume(e0))
                nxt = e1;
            else
                nxt = e0;
        end
        else if (!in_volume(back))
        begin
            if (reversed_reg)
                res_err = ERR_SECOND_REVERSAL;
            else if (!other_valid_reg)
                res_err = ERR_NO_ALTERNATE;
            else
            begin
                rev_act     = 1'b1;
                res_restart = 1'b1;
                nxt         = other_reg;
            end
        end
        else
            nxt = back;
        ex   = $signed({end_reg.x[CW-1], end_reg.x}) - $signed({nxt.x[CW-1], nxt.x});
        ey   = $signed({end_reg.y[CW-1], end_reg.y}) - $signed({nxt.y[CW-1], nxt.y});
        ez   = $signed({end_reg.z[CW-1], end_reg.z}) - $signed({nxt.z[CW-1], nxt.z});
        near = (ex >= -1) && (ex <= 1) && (ey >= -1) && (ey <= 1)
            && (ez >= -1) && (ez <= 1);
    end

    // Work registers: item, multiplier pipeline, start search, output word
    always_ff @(posedge clk)
    begin
        prod_reg <= opa_reg * opb_reg;
        if (cmd.load)
            item_reg <= item;
        if (cmd.face_step && (cmd.phase == PH_OPS1 || cmd.phase == PH_OPS2))
        begin
            opa_reg <= opa;
            opb_reg <= opb;
        end
        if (cmd.face_step && cmd.phase == PH_T)
            t_reg <= t_new;
        if (cmd.best_upd && start_hit && (!found_reg || sq_dist < bestd_reg))
        begin
            best_reg  <= cand;
            bestd_reg <= sq_dist;
        end
        if (cmd.finish)
        begin
            out_reg.cube_x  <= nxt.x[3:0];
            out_reg.cube_y  <= nxt.y[3:0];
            out_reg.cube_z  <= nxt.z[5:0];
            out_reg.restart <= res_restart;
            out_reg.last    <= (res_err == ERR_OK) && !is_start && near;
            out_reg.error   <= res_err;
        end
    end

    // Control flags and track state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg       <= 1'b0;
            mask_reg        <= '0;
            out_valid_reg   <= 1'b0;
            cur_reg         <= '0;
            prev_reg        <= '0;
            first_reg       <= '0;
            other_reg       <= '0;
            end_reg         <= '0;
            prev_valid_reg  <= 1'b0;
            other_valid_reg <= 1'b0;
            reversed_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                found_reg <= 1'b0;
            else if (cmd.best_upd && start_hit)
                found_reg <= 1'b1;
            if (cmd.mask_clr)
                mask_reg <= '0;
            else if (cmd.face_step && cmd.phase == PH_HIT)
                mask_reg[cmd.face] <= hit;
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
            if (cmd.finish && res_err == ERR_OK)
            begin
                cur_reg <= nxt;
                if (is_start)
                begin
                    end_reg.x       <= {{(CW-4){1'b0}}, item_reg.goal_x};
                    end_reg.y       <= {{(CW-4){1'b0}}, item_reg.goal_y};
                    end_reg.z       <= {{(CW-6){1'b0}}, item_reg.goal_z};
                    prev_valid_reg  <= 1'b0;
                    other_valid_reg <= 1'b0;
                    reversed_reg    <= 1'b0;
                end
                else if (first_act)
                begin
                    first_reg      <= cur_reg;
                    prev_reg       <= cur_reg;
                    prev_valid_reg <= 1'b1;
                    if (ow_set)
                    begin
                        other_reg       <= e1;
                        other_valid_reg <= 1'b1;
                    end
                end
                else if (rev_act)
                begin
                    prev_reg     <= first_reg;
                    reversed_reg <= 1'b1;
                end
                else
                begin
                    prev_reg <= cur_reg;
                end
            end
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    always_comb
    begin
        status.is_start    = is_start;
        status.cand_in_vol = in_volume(cand);
        status.out_busy    = out_valid_reg && !result_ready;
    end

`ifndef ASSERT_OFF
    a_err_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.error == ERR_OK || (!result.restart && !result.last)))
        else $error("error word carries restart or last");

    a_restart_rev: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && res_restart) |=> reversed_reg)
        else $error("restart without reversal recorded");

    a_two_exits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && !is_start && res_err == ERR_OK) |-> ($countones(mask_reg) == 2))
        else $error("advance taken without exactly two exits");
`endif

endmodule
